// File: sv/csrmv_pkg.sv
package csrmv_pkg;

	// Field widths fixed by the item formats
	localparam int unsigned ACT_W = 2;
	localparam int unsigned POS_W = 10;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned ROW_W = 16;
	localparam int unsigned ACC_W = 64;

	// Request codes
	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_NONZERO = 2'd1;
	localparam logic [ACT_W-1:0] ACT_EMPTY   = 2'd2;

	// Saturation limits of the row sum
	localparam logic signed [VAL_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] SUM_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		logic                    row_end;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0]        row_number;
		logic signed [VAL_W-1:0] row_sum;
		logic                    last_row;
		logic                    saturated;
	} result_t;

	// Request handed to the multiply-accumulate pipeline
	typedef struct packed {
		logic                    valid;
		logic                    empty;
		logic signed [VAL_W-1:0] value;
		logic                    row_end;
		logic                    in_range;
	} issue_t;

	// Finished row accumulation handed to the output stage
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] acc;
	} row_acc_t;

endpackage

// File: sv/csrmv_ram.sv
module csrmv_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/csrmv_mac.sv
module csrmv_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  csrmv_pkg::issue_t                     issue,
	input  logic [csrmv_pkg::VAL_W-1:0]           rd_data,
	input  logic                                  take,
	output logic                                  ready,
	output csrmv_pkg::row_acc_t                   row_acc
);

	// Stage 1: request waits for the vector element
	logic                               valid_s1;
	logic                               empty_s1;
	logic signed [csrmv_pkg::VAL_W-1:0] value_s1;
	logic                               row_end_s1;
	logic                               in_range_s1;

	// Stage 2: product
	logic                               valid_s2;
	logic                               empty_s2;
	logic                               row_end_s2;
	logic signed [csrmv_pkg::ACC_W-1:0] prod_s2;

	// Stage 3: finished row sum
	logic                               valid_s3;
	logic [csrmv_pkg::ACC_W-1:0]        acc_s3;

	logic [csrmv_pkg::ACC_W-1:0]        acc_q;
	logic [csrmv_pkg::ACC_W-1:0]        acc_next;
	logic signed [csrmv_pkg::VAL_W-1:0] elem;
	logic                               free_s3;
	logic                               free_s2;
	logic                               adv_s2;
	logic                               emit_s2;

	// Let each stage refill when empty or when it drains downstream
	assign free_s3 = !valid_s3 || take;
	assign free_s2 = !valid_s2 || free_s3;
	assign ready   = !valid_s1 || free_s2;
	assign adv_s2  = valid_s2 && free_s3;
	assign emit_s2 = empty_s2 || row_end_s2;

	// Use zero for columns beyond the store
	assign elem     = in_range_s1 ? $signed(rd_data) : '0;
	assign acc_next = acc_q + prod_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready) begin
				valid_s1 <= issue.valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= adv_s2 && emit_s2;
			end
		end
	end

	// Accumulate, clear on row end or empty row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv_s2) begin
			if (emit_s2) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ready) begin
			empty_s1    <= issue.empty;
			value_s1    <= issue.value;
			row_end_s1  <= issue.row_end;
			in_range_s1 <= issue.in_range;
		end
		if (free_s2) begin
			empty_s2   <= empty_s1;
			row_end_s2 <= row_end_s1;
			prod_s2    <= csrmv_pkg::ACC_W'(value_s1) * csrmv_pkg::ACC_W'(elem);
		end
		if (adv_s2) begin
			acc_s3 <= empty_s2 ? '0 : acc_next;
		end
	end

	assign row_acc.valid = valid_s3;
	assign row_acc.acc   = acc_s3;

	// An empty pipeline never stalls the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> ready)
		else $error("pipeline empty but not ready");

	// A row that leaves the adder leaves the accumulator clear
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && emit_s2 |=> acc_q == '0)
		else $error("accumulator not cleared after row emit");

endmodule

// File: sv/csrmv_out.sv
module csrmv_out #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csrmv_pkg::row_acc_t           row_acc,
	input  logic [csrmv_pkg::ROW_W-1:0]   row_count,
	input  logic                          result_stall,
	output logic                          take,
	output logic                          result_valid,
	output csrmv_pkg::result_t            result
);

	localparam int unsigned HI_W = csrmv_pkg::ACC_W - FRAC_BITS - csrmv_pkg::VAL_W + 1;

	logic                               out_valid_q;
	csrmv_pkg::result_t                 out_q;
	logic [csrmv_pkg::ROW_W-1:0]        row_counter_q;
	logic [csrmv_pkg::ROW_W-1:0]        last_idx;
	logic [HI_W-1:0]                    hi_bits;
	logic                               fits;
	logic signed [csrmv_pkg::VAL_W-1:0] sum;
	logic                               at_last;
	logic                               wrap;

	assign take = !out_valid_q || !result_stall;

	// Treat a zero row count as one
	assign last_idx = (row_count == '0) ? '0 : row_count - 1'b1;
	assign at_last  = row_counter_q == last_idx;
	assign wrap     = row_counter_q >= last_idx;

	// Shift out the fraction and clip to 32 bits
	assign hi_bits = row_acc.acc[csrmv_pkg::ACC_W-1 -: HI_W];
	assign fits    = (&hi_bits) || !(|hi_bits);
	assign sum     = fits ? $signed(row_acc.acc[FRAC_BITS +: csrmv_pkg::VAL_W])
		: (row_acc.acc[csrmv_pkg::ACC_W-1] ? csrmv_pkg::SUM_MIN : csrmv_pkg::SUM_MAX);

	// Output valid and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			row_counter_q <= '0;
		end else if (take) begin
			out_valid_q <= row_acc.valid;
			if (row_acc.valid) begin
				row_counter_q <= wrap ? '0 : row_counter_q + 1'b1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take && row_acc.valid) begin
			out_q.row_number <= row_counter_q;
			out_q.row_sum    <= sum;
			out_q.last_row   <= at_last;
			out_q.saturated  <= !fits;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// A clipped sum sits at one of the limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |->
			(result.row_sum == csrmv_pkg::SUM_MAX || result.row_sum == csrmv_pkg::SUM_MIN))
		else $error("saturated sum not at a limit");

	// The counter returns to zero after the last row
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && row_acc.valid && at_last |=> row_counter_q == '0)
		else $error("row counter did not wrap");

endmodule

// File: sv/sparse_csr_matrix_vector_product.sv
// Sparse matrix times dense vector in compressed-row order. Load the vector
// first with load requests (one element each), then stream the nonzeros of each
// row with their column; the nonzero flagged as row end, or an empty-row request,
// yields one result with the row index, the Q16.16 sum saturated to 32 bits and
// its flags. The block takes one request every cycle unless item_stall is high;
// a request reads the vector store on the edge that accepts it, then passes the
// multiply, accumulate and output registers, and stall on the result side backs
// up through those stages. The vector store has no reset and no clearing pass:
// read only entries that were loaded. Write row_count only while the block is idle.
module sparse_csr_matrix_vector_product #(
	parameter int unsigned VECTOR_DEPTH = 1024,
	parameter int unsigned FRAC_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  csrmv_pkg::item_t            item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output csrmv_pkg::result_t          result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [csrmv_pkg::ROW_W-1:0] cfg_data
);

	localparam int unsigned AW    = $clog2(VECTOR_DEPTH);
	localparam int unsigned CMP_W = 17;

	logic                          accept;
	logic                          ready;
	logic                          take;
	logic                          in_range;
	logic [AW-1:0]                 addr;
	logic [CMP_W-1:0]              pos_ext;
	logic [csrmv_pkg::VAL_W-1:0]   rd_data;
	logic [csrmv_pkg::ROW_W-1:0]   row_count_q;
	csrmv_pkg::issue_t             issue;
	csrmv_pkg::row_acc_t           row_acc;

	assign item_stall = !ready;
	assign accept     = item_valid && ready;
	assign cfg_ready  = 1'b1;

	// Decode position against the store depth
	assign pos_ext  = CMP_W'(item.position);
	assign in_range = pos_ext < CMP_W'(VECTOR_DEPTH);
	assign addr     = AW'(pos_ext);

	// Row count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= csrmv_pkg::ROW_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			row_count_q <= cfg_data;
		end
	end

	// Hand nonzero and empty-row requests to the pipeline, drop the rest
	always_comb begin
		issue.valid    = accept && (item.action == csrmv_pkg::ACT_NONZERO
			|| item.action == csrmv_pkg::ACT_EMPTY);
		issue.empty    = item.action == csrmv_pkg::ACT_EMPTY;
		issue.value    = item.value;
		issue.row_end  = item.row_end;
		issue.in_range = in_range;
	end

	csrmv_ram #(
		.WIDTH(csrmv_pkg::VAL_W),
		.DEPTH(VECTOR_DEPTH)
	) u_vector_store (
		.clk    (clk),
		.wr_en  (accept && item.action == csrmv_pkg::ACT_LOAD && in_range),
		.wr_addr(addr),
		.wr_data(item.value),
		.rd_en  (accept && item.action == csrmv_pkg::ACT_NONZERO),
		.rd_addr(addr),
		.rd_data(rd_data)
	);

	csrmv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.rd_data(rd_data),
		.take   (take),
		.ready  (ready),
		.row_acc(row_acc)
	);

	csrmv_out #(
		.FRAC_BITS(FRAC_BITS)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_acc     (row_acc),
		.row_count   (row_count_q),
		.result_stall(result_stall),
		.take        (take),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
